@@ rtl/aes256ke_pkg.sv @@
// Shared types, constants and tables for the AES-256 key schedule generator.
// Used by aes256ke_subword and aes256_key_expansion; depends on nothing else.
package aes256ke_pkg;

    // Schedule geometry: eight key words expand to sixty schedule words.
    localparam int unsigned KEY_WORDS   = 8;
    localparam int unsigned SCHED_WORDS = 60;
    localparam int unsigned IDX_W       = 6;

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(SCHED_WORDS - 1);

    // Word positions inside each group of eight that get special treatment.
    localparam logic [2:0] POS_ROT_SUB = 3'd0;
    localparam logic [2:0] POS_SUB     = 3'd4;

    // One input item: the 256-bit key as eight words, word 0 in the top bits.
    typedef struct packed {
        logic [31:0] key_word_0;
        logic [31:0] key_word_1;
        logic [31:0] key_word_2;
        logic [31:0] key_word_3;
        logic [31:0] key_word_4;
        logic [31:0] key_word_5;
        logic [31:0] key_word_6;
        logic [31:0] key_word_7;
    } t_key_item;

    // One result item: a schedule word with its position.
    typedef struct packed {
        logic [IDX_W-1:0] word_index;
        logic [31:0]      round_key_word;
        logic             last;
    } t_word_item;

    // Control for the shared substitution unit.
    typedef struct packed {
        logic       sub_en;
        logic       rot_en;
        logic [7:0] rcon;
    } t_sub_ctrl;

    // Round constants by group number; entry 0 never feeds a real schedule word.
    localparam logic [7:0] RCON [0:7] = '{
        8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
    };

    // AES forward S-box.
    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,
        8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,
        8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,
        8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,
        8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,
        8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,
        8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,
        8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,
        8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,
        8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,
        8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,
        8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,
        8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,
        8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,
        8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,
        8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,
        8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

endpackage

@@ rtl/aes256ke_subword.sv @@
// Shared temp-word unit of the key schedule: optional byte rotate, S-box
// substitution of all four bytes and round-constant insertion. Uses aes256ke_pkg.
module aes256ke_subword
    import aes256ke_pkg::*;
(
    input  logic [31:0] i_word,
    input  t_sub_ctrl   i_ctrl,
    output logic [31:0] o_temp
);

    logic [31:0] rot_word;
    logic [31:0] sub_word;

    // Rotate left by one byte when the group boundary asks for it.
    assign rot_word = i_ctrl.rot_en ? {i_word[23:0], i_word[31:24]} : i_word;

    // Four parallel S-box lookups.
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            sub_word[b*8 +: 8] = SBOX[rot_word[b*8 +: 8]];
        end
    end

    // Words outside the special positions pass unchanged.
    assign o_temp = i_ctrl.sub_en ? (sub_word ^ {i_ctrl.rcon, 24'h000000}) : i_word;

endmodule

@@ rtl/aes256_key_expansion.sv @@
// AES-256 key schedule generator: sequencer, eight-word window and output.
// Uses aes256ke_pkg and the shared unit aes256ke_subword.
//
// Usage:
//   The key channel (i_key_valid / o_key_stall / i_key) takes one 256-bit key
//   per item. The word channel (o_word_valid / i_word_stall / o_word) then
//   delivers the 60 schedule words in index order, one item per word, with
//   last set on index 59.
//   Sequence: the first word (index 0) is offered on the cycle after the key
//   item is accepted. Each further word follows in the cycle after the previous
//   one is taken.
//   Keys: one key is taken at a time; o_key_stall stays high from
//   acceptance until the word with index 59 has been taken.
//   One new schedule word is formed per taken word by the shared substitution
//   unit acting on the newest word of an eight-word sliding window; the
//   window head is the output register.
//   Stall: while i_word_stall is high the offered word and the window hold.
//   Reset (i_rst_n low, synchronous) drops any schedule in progress; the
//   block comes out idle, ready for a key.
module aes256_key_expansion
    import aes256ke_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_key_valid,
    output logic       o_key_stall,
    input  t_key_item  i_key,
    output logic       o_word_valid,
    input  logic       i_word_stall,
    output t_word_item o_word
);

    localparam int unsigned WIN_LAST = KEY_WORDS - 1;

    logic             r_busy;
    logic             n_busy;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [31:0]      r_win [0:KEY_WORDS-1];
    logic [31:0]      n_win [0:KEY_WORDS-1];

    logic        key_take;
    logic        word_take;
    t_sub_ctrl   sub_ctrl;
    logic [31:0] temp_word;
    logic [2:0]  grp_pos;
    logic [2:0]  rcon_sel;

    // Handshake decode.
    assign key_take  = i_key_valid && !r_busy;
    assign word_take = r_busy && !i_word_stall;

    // The next word to form has index r_idx + 8, so it shares r_idx's position.
    assign grp_pos  = r_idx[2:0];
    assign rcon_sel = r_idx[IDX_W-1:3] + 3'd1;

    always_comb begin
        sub_ctrl.sub_en = (grp_pos == POS_ROT_SUB) || (grp_pos == POS_SUB);
        sub_ctrl.rot_en = (grp_pos == POS_ROT_SUB);
        sub_ctrl.rcon   = (grp_pos == POS_ROT_SUB) ? RCON[rcon_sel] : 8'h00;
    end

    aes256ke_subword u_subword (
        .i_word (r_win[WIN_LAST]),
        .i_ctrl (sub_ctrl),
        .o_temp (temp_word)
    );

    // Sequencer and window update.
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        for (int k = 0; k < KEY_WORDS; k++) begin
            n_win[k] = r_win[k];
        end
        if (key_take) begin
            n_busy   = 1'b1;
            n_idx    = '0;
            n_win[0] = i_key.key_word_0;
            n_win[1] = i_key.key_word_1;
            n_win[2] = i_key.key_word_2;
            n_win[3] = i_key.key_word_3;
            n_win[4] = i_key.key_word_4;
            n_win[5] = i_key.key_word_5;
            n_win[6] = i_key.key_word_6;
            n_win[7] = i_key.key_word_7;
        end else if (word_take) begin
            n_idx = r_idx + IDX_W'(1);
            if (r_idx == LAST_INDEX) begin
                n_busy = 1'b0;
            end
            for (int k = 0; k < KEY_WORDS - 1; k++) begin
                n_win[k] = r_win[k+1];
            end
            n_win[WIN_LAST] = r_win[0] ^ temp_word;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    // Window registers; payload only, no reset.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < KEY_WORDS; k++) begin
            r_win[k] <= n_win[k];
        end
    end

    // Outputs.
    assign o_key_stall           = r_busy;
    assign o_word_valid          = r_busy;
    assign o_word.word_index     = r_idx;
    assign o_word.round_key_word = r_win[0];
    assign o_word.last           = (r_idx == LAST_INDEX);

endmodule
